>>> hdl/argb_pixel_alu_top_defines.svh
// Assertion macros used by the checker file of the pixel ALU.
`ifndef ARGB_PIXEL_ALU_TOP_DEFINES_SVH
`define ARGB_PIXEL_ALU_TOP_DEFINES_SVH

// Implication that must hold at every rising clock edge outside reset.
`define APA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pixel ALU check failed");

// Implication whose consequent is due after the delay given by dly.
`define APA_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("pixel ALU latency check failed");

`endif

>>> hdl/apa_pkg.sv
package apa_pkg;

	localparam int CHAN_W               = 8;
	localparam int LANES                = 4;
	localparam int PIXEL_W              = CHAN_W * LANES;
	localparam int FACTOR_W             = 16;
	localparam int FACTOR_FRAC_BITS_DEF = 8;
	localparam int DIV_STAGES           = CHAN_W;
	// Lane pipeline plus the merge register.
	localparam int LATENCY              = DIV_STAGES + 1;
	localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

	typedef enum logic [2:0] {
		OP_ADD      = 3'd0,
		OP_SUBTRACT = 3'd1,
		OP_MODULATE = 3'd2,
		OP_SCALE    = 3'd3,
		OP_DIVIDE   = 3'd4,
		OP_BLEND    = 3'd5
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [CHAN_W-1:0]   x;
		logic [CHAN_W-1:0]   y;
		logic [CHAN_W-1:0]   t;
		logic                neg;
		logic                mag_zero;
		logic [FACTOR_W-1:0] mag;
	} lane_in_t;

	typedef struct packed {
		op_t                op;
		logic               t_zero;
		logic               t_full;
		logic               mag_zero;
		logic [PIXEL_W-1:0] pa;
		logic [PIXEL_W-1:0] pb;
	} ctrl_t;

endpackage

>>> hdl/apa_div.sv
module apa_div #(
	parameter int FRAC = apa_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic [apa_pkg::CHAN_W-1:0]    x,
	input  logic [apa_pkg::FACTOR_W-1:0]  mag,
	output logic [apa_pkg::CHAN_W-1:0]    quo
);

	localparam int CW     = apa_pkg::CHAN_W;
	localparam int MW     = apa_pkg::FACTOR_W;
	localparam int STAGES = apa_pkg::DIV_STAGES;
	localparam int DW     = (CW + FRAC > MW + CW) ? CW + FRAC : MW + CW;

	logic [DW-1:0] rem_s [STAGES];
	logic [CW-1:0] quo_s [STAGES];
	logic [MW-1:0] mag_s [STAGES];
	logic          ovf_s [STAGES];

	// One quotient bit per stage, restoring form. A quotient above the
	// channel range is caught up front and saturates at the end.
	for (genvar k = 0; k < STAGES; k++) begin : g_step
		logic [DW-1:0] rem_i;
		logic [DW-1:0] trial;
		logic [CW-1:0] quo_i;
		logic [MW-1:0] mag_i;
		logic          ovf_i;

		if (k == 0) begin : g_first
			assign rem_i = DW'(x) << FRAC;
			assign quo_i = '0;
			assign mag_i = mag;
			assign ovf_i = (DW'(x) << FRAC) >= (DW'(mag) << CW);
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign quo_i = quo_s[k-1];
			assign mag_i = mag_s[k-1];
			assign ovf_i = ovf_s[k-1];
		end

		assign trial = DW'(mag_i) << (STAGES - 1 - k);

		always_ff @(posedge clk) begin
			if (rem_i >= trial) begin
				rem_s[k] <= rem_i - trial;
				quo_s[k] <= quo_i | (CW'(1) << (STAGES - 1 - k));
			end else begin
				rem_s[k] <= rem_i;
				quo_s[k] <= quo_i;
			end
			mag_s[k] <= mag_i;
			ovf_s[k] <= ovf_i;
		end
	end

	assign quo = ovf_s[STAGES-1] ? apa_pkg::CHAN_MAX : quo_s[STAGES-1];

endmodule

>>> hdl/apa_lane.sv
module apa_lane #(
	parameter int FRAC = apa_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  apa_pkg::lane_in_t          lin,
	output logic [apa_pkg::CHAN_W-1:0] res
);

	localparam int CW    = apa_pkg::CHAN_W;
	localparam int MW    = apa_pkg::FACTOR_W;
	localparam int PW    = CW + MW;
	localparam int DELAY = apa_pkg::DIV_STAGES - 2;

	logic [CW:0]   sum;
	logic [CW-1:0] addsub;
	logic [CW-1:0] mul_a;
	logic [MW-1:0] mul_b;
	logic [CW-1:0] diff;

	apa_pkg::op_t  op_s1;
	logic [CW-1:0] addsub_s1;
	logic [PW-1:0] prod_s1;
	logic          flip_s1;
	logic [CW-1:0] x_s1;
	logic          neg_s1;
	logic          mzero_s1;

	logic [2*CW:0] div255;
	logic [CW-1:0] q255;
	logic [PW-1:0] scaled;
	logic [CW-1:0] scale_sat;
	logic [CW-1:0] r_s2;
	logic          use_div_s2;

	logic [CW-1:0] r_sn   [DELAY];
	logic          use_sn [DELAY];
	logic [CW-1:0] div_q;

	always_comb begin
		sum  = {1'b0, lin.x} + {1'b0, lin.y};
		diff = (lin.y >= lin.x) ? lin.y - lin.x : lin.x - lin.y;
		case (lin.op)
			apa_pkg::OP_ADD:      addsub = sum[CW] ? apa_pkg::CHAN_MAX : sum[CW-1:0];
			apa_pkg::OP_SUBTRACT: addsub = (lin.x > lin.y) ? lin.x - lin.y : '0;
			default:              addsub = '0;
		endcase
		case (lin.op)
			apa_pkg::OP_MODULATE: begin
				mul_a = lin.x;
				mul_b = MW'(lin.y);
			end
			apa_pkg::OP_BLEND: begin
				mul_a = lin.t;
				mul_b = MW'(diff);
			end
			apa_pkg::OP_SCALE: begin
				mul_a = lin.x;
				mul_b = lin.mag;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_s1     <= lin.op;
		addsub_s1 <= addsub;
		prod_s1   <= PW'(mul_a) * PW'(mul_b);
		flip_s1   <= lin.y < lin.x;
		x_s1      <= lin.x;
		neg_s1    <= lin.neg;
		mzero_s1  <= lin.mag_zero;
	end

	// Exact floor(p/255) for products of two channel values.
	always_comb begin
		div255    = {1'b0, prod_s1[2*CW-1:0]} + (2*CW+1)'(prod_s1[2*CW-1:CW])
			+ (2*CW+1)'(1);
		q255      = div255[2*CW-1:CW];
		scaled    = prod_s1 >> FRAC;
		scale_sat = (|scaled[PW-1:CW]) ? apa_pkg::CHAN_MAX : scaled[CW-1:0];
	end

	always_ff @(posedge clk) begin
		use_div_s2 <= (op_s1 == apa_pkg::OP_DIVIDE) && !neg_s1 && !mzero_s1;
		case (op_s1)
			apa_pkg::OP_ADD,
			apa_pkg::OP_SUBTRACT: r_s2 <= addsub_s1;
			apa_pkg::OP_MODULATE: r_s2 <= q255;
			apa_pkg::OP_BLEND:    r_s2 <= flip_s1 ? x_s1 - q255 : x_s1 + q255;
			apa_pkg::OP_SCALE:    r_s2 <= (neg_s1 || mzero_s1) ? '0 : scale_sat;
			apa_pkg::OP_DIVIDE: begin
				if (mzero_s1 && !neg_s1 && (x_s1 != '0))
					r_s2 <= apa_pkg::CHAN_MAX;
				else
					r_s2 <= '0;
			end
			default:              r_s2 <= '0;
		endcase
	end

	always_ff @(posedge clk) begin
		r_sn[0]   <= r_s2;
		use_sn[0] <= use_div_s2;
		for (int i = 1; i < DELAY; i++) begin
			r_sn[i]   <= r_sn[i-1];
			use_sn[i] <= use_sn[i-1];
		end
	end

	apa_div #(.FRAC(FRAC)) u_div (
		.clk (clk),
		.x   (lin.x),
		.mag (lin.mag),
		.quo (div_q)
	);

	assign res = use_sn[DELAY-1] ? div_q : r_sn[DELAY-1];

endmodule

>>> hdl/apa_merge.sv
module apa_merge (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         vld,
	input  apa_pkg::ctrl_t                               ctrl,
	input  logic [apa_pkg::LANES-1:0][apa_pkg::CHAN_W-1:0] lane_res,
	output logic                                         done,
	output logic [apa_pkg::PIXEL_W-1:0]                  pixel_out,
	output logic                                         divide_by_zero
);

	localparam int CW = apa_pkg::CHAN_W;

	logic [apa_pkg::PIXEL_W-1:0] pix;
	logic                        done_q;
	logic [apa_pkg::PIXEL_W-1:0] pix_q;
	logic                        dz_q;

	always_comb begin
		case (ctrl.op)
			apa_pkg::OP_ADD,
			apa_pkg::OP_SUBTRACT,
			apa_pkg::OP_MODULATE: pix = lane_res;
			apa_pkg::OP_SCALE,
			apa_pkg::OP_DIVIDE:   pix = {CW'(0), lane_res[2], lane_res[1], lane_res[0]};
			apa_pkg::OP_BLEND: begin
				if (ctrl.t_zero)
					pix = ctrl.pa;
				else if (ctrl.t_full)
					pix = ctrl.pb;
				else
					pix = {CW'(0), lane_res[2], lane_res[1], lane_res[0]};
			end
			default:              pix = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	// The flag is only raised together with a result beat.
	always_ff @(posedge clk) begin
		pix_q <= pix;
		dz_q  <= vld && (ctrl.op == apa_pkg::OP_DIVIDE) && ctrl.mag_zero;
	end

	assign done           = done_q;
	assign pixel_out      = pix_q;
	assign divide_by_zero = dz_q;

endmodule

>>> hdl/argb_pixel_alu_top.sv
// A beat accepted on start passes the lane and valid pipelines and the merge
// register, then shows on done, pixel_out and divide_by_zero. Throughput: one beat
// per cycle, set by the eight-stage per-channel divider and the lane pipeline that
// runs alongside it. busy is always low, and the receiver cannot stall: each result
// beat is shown for one cycle. arst_n clears the valid pipeline at once; data registers hold.
module argb_pixel_alu_top #(
	parameter int FACTOR_FRAC_BITS = apa_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          opcode,
	input  logic [apa_pkg::PIXEL_W-1:0]         pixel_a,
	input  logic [apa_pkg::PIXEL_W-1:0]         pixel_b,
	input  logic signed [apa_pkg::FACTOR_W-1:0] factor,
	output logic                                done,
	output logic [apa_pkg::PIXEL_W-1:0]         pixel_out,
	output logic                                divide_by_zero
);

	localparam int CW     = apa_pkg::CHAN_W;
	localparam int LANES  = apa_pkg::LANES;
	localparam int STAGES = apa_pkg::DIV_STAGES;
	localparam int PTOP   = apa_pkg::PIXEL_W - 1;

	// The block never refuses a beat: every stage advances every cycle.
	logic                                 accept;
	logic [apa_pkg::FACTOR_W-1:0]         mag;
	logic                                 neg;
	apa_pkg::ctrl_t                       ctrl_in;
	apa_pkg::ctrl_t                       ctrl_s [STAGES];
	logic [STAGES-1:0]                    vld_q;
	logic [LANES-1:0][CW-1:0]             lane_res;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// The factor is split into sign and magnitude once and shared by all
	// lanes. A negative factor drives scale and divide results to zero.
	assign neg = factor[apa_pkg::FACTOR_W-1];
	assign mag = neg ? apa_pkg::FACTOR_W'(~factor) + apa_pkg::FACTOR_W'(1)
		: apa_pkg::FACTOR_W'(factor);

	always_comb begin
		ctrl_in.op       = apa_pkg::op_t'(opcode);
		ctrl_in.t_zero   = pixel_a[PTOP -: CW] == '0;
		ctrl_in.t_full   = pixel_a[PTOP -: CW] == apa_pkg::CHAN_MAX;
		ctrl_in.mag_zero = factor == '0;
		ctrl_in.pa       = pixel_a;
		ctrl_in.pb       = pixel_b;
	end

	// One lane per channel; the alpha lane serves add, subtract and modulate,
	// and the blend weight is pixel A's alpha in every lane.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		apa_pkg::lane_in_t lin;

		always_comb begin
			lin.op       = apa_pkg::op_t'(opcode);
			lin.x        = pixel_a[i*CW +: CW];
			lin.y        = pixel_b[i*CW +: CW];
			lin.t        = pixel_a[PTOP -: CW];
			lin.neg      = neg;
			lin.mag_zero = factor == '0;
			lin.mag      = mag;
		end

		apa_lane #(.FRAC(FACTOR_FRAC_BITS)) u_lane (
			.clk (clk),
			.lin (lin),
			.res (lane_res[i])
		);
	end

	// Valid bits and the per-beat control ride alongside the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[STAGES-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s[0] <= ctrl_in;
		for (int i = 1; i < STAGES; i++)
			ctrl_s[i] <= ctrl_s[i-1];
	end

	apa_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.vld            (vld_q[STAGES-1]),
		.ctrl           (ctrl_s[STAGES-1]),
		.lane_res       (lane_res),
		.done           (done),
		.pixel_out      (pixel_out),
		.divide_by_zero (divide_by_zero)
	);

endmodule

>>> hdl/apa_checker.sv
`include "argb_pixel_alu_top_defines.svh"

module apa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [apa_pkg::PIXEL_W-1:0] pixel_out,
	input logic                        divide_by_zero
);

	`APA_ASSERT_DELAY(a_result_follows, clk, arst_n, start && !busy, 9, done)
	`APA_ASSERT_IMPL(a_no_orphan_result, clk, arst_n, done, $past(start && !busy, 9))
	`APA_ASSERT_IMPL(a_flag_with_strobe, clk, arst_n, divide_by_zero, done)
	`APA_ASSERT_IMPL(a_flag_clears_alpha, clk, arst_n, done && divide_by_zero,
		pixel_out[apa_pkg::PIXEL_W-1 -: apa_pkg::CHAN_W] == '0)

endmodule

bind argb_pixel_alu_top apa_checker u_apa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.pixel_out      (pixel_out),
	.divide_by_zero (divide_by_zero)
);

>>> test/argb_pixel_alu_top_test.sv
module argb_pixel_alu_top_test;
	import apa_pkg::*;

	localparam int FRAC = FACTOR_FRAC_BITS_DEF;

	// One beat offered to the ALU, with each field held at its port width.
	typedef struct {
		logic [2:0]  op;
		logic [31:0] pa;
		logic [31:0] pb;
		logic [15:0] fac;
	} pixel_cmd_t;

	// One result beat as the ALU should produce it.
	typedef struct {
		logic [31:0] pix;
		logic        dz;
	} pixel_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [31:0] pixel_a;
	logic [31:0] pixel_b;
	logic signed [15:0] factor;
	logic        done;
	logic [31:0] pixel_out;
	logic        divide_by_zero;

	pixel_cmd_t cmd_fifo[$];
	pixel_res_t pixel_expected[$];
	int         mismatch_count;
	bit         stim_done;
	// While set, the driver may not offer a new beat (idle windows and drains).
	bit         hold_off;
	// While set, the driver never inserts random idle cycles.
	bit         no_idle;

	argb_pixel_alu_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.pixel_a       (pixel_a),
		.pixel_b       (pixel_b),
		.factor        (factor),
		.done          (done),
		.pixel_out     (pixel_out),
		.divide_by_zero(divide_by_zero)
	);

	always #5 clk = ~clk;

	// Golden per-channel ALU. Channel results are built as plain integers and
	// clamped before packing, so no intermediate can wrap.
	function automatic pixel_res_t alu_predict(pixel_cmd_t c);
		pixel_res_t r;
		int         x;
		int         y;
		int         v;
		int         t;
		int         mag;
		bit         neg;
		logic [7:0] ch[4];
		r.pix = '0;
		r.dz  = 1'b0;
		neg   = c.fac[15];
		mag   = neg ? (32'h10000 - int'(c.fac)) : int'(c.fac);
		t     = int'(c.pa[31:24]);
		for (int i = 0; i < 4; i++) begin
			x = int'(c.pa[8*i +: 8]);
			y = int'(c.pb[8*i +: 8]);
			v = 0;
			case (c.op)
				OP_ADD:      v = (x + y > 255) ? 255 : x + y;
				OP_SUBTRACT: v = (x > y) ? x - y : 0;
				OP_MODULATE: v = (x * y) / 255;
				OP_SCALE: begin
					// Negative or zero factors floor to zero; alpha is dropped.
					if (i < 3 && !neg && mag != 0)
						v = (x * mag) >> FRAC;
				end
				OP_DIVIDE: begin
					if (i < 3) begin
						if (mag == 0)
							v = (x != 0) ? 255 : 0;
						else if (!neg)
							v = (x << FRAC) / mag;
					end
				end
				OP_BLEND: begin
					// Pixel A's alpha is the transmittance toward pixel B.
					if (i < 3)
						v = (y >= x) ? x + (t * (y - x)) / 255 : x - (t * (x - y)) / 255;
				end
				default: v = 0;
			endcase
			ch[i] = (v > 255) ? 8'hff : v[7:0];
		end
		r.pix = {ch[3], ch[2], ch[1], ch[0]};
		if (c.op == OP_DIVIDE && mag == 0)
			r.dz = 1'b1;
		// The blend ends pass a whole pixel through, alpha included.
		if (c.op == OP_BLEND && t == 0)
			r.pix = c.pa;
		if (c.op == OP_BLEND && t == 255)
			r.pix = c.pb;
		return r;
	endfunction

	function automatic pixel_cmd_t make_cmd(logic [2:0] op, logic [31:0] pa,
		logic [31:0] pb, logic [15:0] fac);
		pixel_cmd_t c;
		c.op  = op;
		c.pa  = pa;
		c.pb  = pb;
		c.fac = fac;
		return c;
	endfunction

	// Random pixels lean toward channel extremes so that clamps get hit often.
	function automatic logic [31:0] rand_pixel();
		logic [31:0] p;
		p = $urandom;
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 7))
				0: p[8*i +: 8] = 8'h00;
				1: p[8*i +: 8] = 8'hff;
				default: ;
			endcase
		end
		return p;
	endfunction

	function automatic logic [15:0] rand_factor();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'($urandom_range(1, 1024));
			2: return 16'(-$urandom_range(1, 1024));
			default: return 16'($urandom);
		endcase
	endfunction

	// Driver: a beat is accepted at a rising edge with start high and busy low,
	// so the next beat is chosen on the falling edge that follows. Each output
	// signal gets at most one nonblocking assignment per falling edge.
	always @(negedge clk) begin
		pixel_cmd_t c;
		bit         offer;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			offer = !hold_off && cmd_fifo.size() != 0 && (start == 1'b0 || !busy);
			// A beat still waiting on busy must stay on the ports.
			if (start && busy) begin
				start <= 1'b1;
			end else begin
				if (offer && !no_idle && $urandom_range(0, 99) < 23)
					offer = 1'b0;
				if (offer) begin
					c = cmd_fifo.pop_front();
					pixel_expected.push_back(alu_predict(c));
					opcode  <= c.op;
					pixel_a <= c.pa;
					pixel_b <= c.pb;
					factor  <= c.fac;
				end else begin
					// Idle cycles carry junk so that the block must ignore it.
					opcode  <= 3'($urandom);
					pixel_a <= $urandom;
					pixel_b <= $urandom;
					factor  <= 16'($urandom);
				end
				start <= offer;
			end
		end
	end

	// Monitor: each done beat is checked against the oldest prediction.
	always @(posedge clk) begin
		pixel_res_t e;
		if (arst_n && done) begin
			if (pixel_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: pixel_out=%h divide_by_zero=%b",
						pixel_out, divide_by_zero);
			end else begin
				e = pixel_expected.pop_front();
				if (pixel_out !== e.pix || divide_by_zero !== e.dz) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result beat wrong: expected %h/%b, got %h/%b",
							e.pix, e.dz, pixel_out, divide_by_zero);
				end
			end
		end
	end

	// Stimulus: a directed set first, then random beats. Most random beats use
	// the six defined opcodes; a few hit the unused codes.
	initial begin
		logic [2:0] op;
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		opcode         = '0;
		pixel_a        = '0;
		pixel_b        = '0;
		factor         = '0;
		mismatch_count = 0;
		stim_done      = 1'b0;
		hold_off       = 1'b1;
		no_idle        = 1'b0;

		// Channel extremes for the saturating add, subtract and modulate.
		cmd_fifo.push_back(make_cmd(OP_ADD, 32'hffffffff, 32'hffffffff, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_ADD, 32'h00000000, 32'h00000000, 16'hffff));
		cmd_fifo.push_back(make_cmd(OP_SUBTRACT, 32'h00000000, 32'hffffffff, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_SUBTRACT, 32'hffffffff, 32'h00000000, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_MODULATE, 32'hffffffff, 32'hffffffff, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_MODULATE, 32'h80ff0180, 32'h80ff01ff, 16'h0000));
		// Scale by one, by the largest factor, by negative factors and by zero.
		cmd_fifo.push_back(make_cmd(OP_SCALE, 32'hff804020, 32'h0, 16'h0100));
		cmd_fifo.push_back(make_cmd(OP_SCALE, 32'hffffffff, 32'h0, 16'h7fff));
		cmd_fifo.push_back(make_cmd(OP_SCALE, 32'hffffffff, 32'h0, 16'h8000));
		cmd_fifo.push_back(make_cmd(OP_SCALE, 32'h12345678, 32'h0, 16'hff00));
		cmd_fifo.push_back(make_cmd(OP_SCALE, 32'h00ffffff, 32'h0, 16'h0000));
		// Divide with a zero divisor, the smallest and the largest divisor, a negative one, and two.
		cmd_fifo.push_back(make_cmd(OP_DIVIDE, 32'hff00ff01, 32'h0, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_DIVIDE, 32'h00000000, 32'h0, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_DIVIDE, 32'hffffffff, 32'h0, 16'h0001));
		cmd_fifo.push_back(make_cmd(OP_DIVIDE, 32'h00ff8001, 32'h0, 16'h7fff));
		cmd_fifo.push_back(make_cmd(OP_DIVIDE, 32'h00ffffff, 32'h0, 16'hffff));
		cmd_fifo.push_back(make_cmd(OP_DIVIDE, 32'h00804020, 32'h0, 16'h0200));
		// Blend at both ends and in between, in both channel directions.
		cmd_fifo.push_back(make_cmd(OP_BLEND, 32'h00123456, 32'hffabcdef, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_BLEND, 32'hff123456, 32'h7fabcdef, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_BLEND, 32'h01ff00ff, 32'h0000ff00, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_BLEND, 32'hfeff00ff, 32'h0000ff00, 16'h0000));
		cmd_fifo.push_back(make_cmd(OP_BLEND, 32'h80ff00ff, 32'hff00ff00, 16'h0000));
		// The two unused opcodes.
		cmd_fifo.push_back(make_cmd(3'd6, 32'hffffffff, 32'hffffffff, 16'hffff));
		cmd_fifo.push_back(make_cmd(3'd7, 32'hffffffff, 32'hffffffff, 16'h0000));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n   = 1'b1;
		hold_off = 1'b0;

		// Wait out the directed set, then pause until every result is back.
		wait (cmd_fifo.size() == 0);
		hold_off = 1'b1;
		wait (pixel_expected.size() == 0);
		hold_off = 1'b0;

		for (int n = 0; n < 1900; n++) begin
			op = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			cmd_fifo.push_back(make_cmd(op, rand_pixel(), rand_pixel(), rand_factor()));
			// A stretch around the middle runs back to back with no idling.
			if (n == 800)
				no_idle = 1'b1;
			if (n == 1100)
				no_idle = 1'b0;
			if (cmd_fifo.size() > 8)
				wait (cmd_fifo.size() <= 8);
		end

		wait (cmd_fifo.size() == 0);
		wait (pixel_expected.size() == 0);
		// Let any stray beat that would follow the last one show itself.
		repeat (LATENCY + 5) @(posedge clk);
		stim_done = 1'b1;
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: set far beyond the slowest correct run.
	initial begin
		#500000;
		if (!stim_done) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

>>> argb_pixel_alu_top.f
+incdir+hdl
hdl/apa_pkg.sv
hdl/apa_div.sv
hdl/apa_lane.sv
hdl/apa_merge.sv
hdl/argb_pixel_alu_top.sv
hdl/apa_checker.sv
test/argb_pixel_alu_top_test.sv
